// ===== rtl/qdv_pkg.sv =====
// Shared types, codes and constants of the queue with delete by value.
`timescale 1ns / 1ps

package qdv_pkg;

	// Default number of cells in the chain.
	localparam int DEPTH_DEF = 16;

	// Widths of the request and result fields.
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic               cmp;
		logic               exe;
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] cmp_value;
		logic [VALUE_W-1:0] wr_value;
	} cell_cmd_t;

endpackage

// ===== rtl/qdv_cell.sv =====
// One cell of the queue chain: holds one entry and its compare result.
`timescale 1ns / 1ps

module qdv_cell
	import qdv_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [CW-1:0]      count,
	input  logic [VALUE_W-1:0] next_data,
	input  logic               found_in,
	output logic               found_out,
	output logic [VALUE_W-1:0] data
);

	logic [VALUE_W-1:0] data_q;
	logic               match_s1;
	logic               occupied;
	logic               wr_en;
	logic               shift_en;

	assign occupied = CW'(IDX) < count;

	// The first match from the head, and everything behind it, moves up.
	assign found_out = found_in | match_s1;

	assign wr_en    = cmd.exe && (cmd.op == OP_ENQ) && (count == CW'(IDX));
	assign shift_en = cmd.exe && ((cmd.op == OP_DEQ) || ((cmd.op == OP_DEL) && found_out));

	// Compare phase: note whether this occupied cell holds the searched value.
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			match_s1 <= occupied && (data_q == cmd.cmp_value);
		end
	end

	// Execute phase: take the enqueued value or the neighbour's entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q <= cmd.wr_value;
		end else if (shift_en) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/queue_with_delete_by_value.sv =====
// Top level of the queue with delete by value: controller and chain of cells.
// A request is accepted into the request registers and the compare flags of the cells;
// its result is registered at the end of its execute phase. A new request is not taken
// during an execute phase, and the found flag ripples along the chain in that phase.
// Reset clears the fill count, the busy flag and the result valid flag; entries
// are undefined until written, and no clearing pass is needed.
`timescale 1ns / 1ps

module queue_with_delete_by_value
	import qdv_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // operation [1:0], value [33:2], zero [39:34]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status [1:0], out_value [33:2], occupancy [38:34]
);

	logic                busy_q;
	logic [OP_W-1:0]     op_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic                accept;
	cell_cmd_t           cmd;
	logic [VALUE_W-1:0]  cell_data [DEPTH];
	logic [VALUE_W-1:0]  cell_next [DEPTH];
	logic [DEPTH:0]      found;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  out_value;
	logic [CW-1:0]       count_d;
	logic [CW+OCC_W-1:0] occ_ext;

	// A request is taken only when no request is at work and the result slot is free.
	assign s_tready = !busy_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign cmd.cmp       = accept;
	assign cmd.exe       = busy_q;
	assign cmd.op        = op_q;
	assign cmd.cmp_value = s_tdata[OP_W +: VALUE_W];
	assign cmd.wr_value  = value_q;

	// Chain of cells, head in cell zero.
	assign found[0] = 1'b0;
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			if (i == DEPTH - 1) begin : g_tail
				assign cell_next[i] = cell_data[i];
			end else begin : g_mid
				assign cell_next[i] = cell_data[i+1];
			end
			qdv_cell #(
				.DEPTH(DEPTH),
				.IDX  (i)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.count    (count_q),
				.next_data(cell_next[i]),
				.found_in (found[i]),
				.found_out(found[i+1]),
				.data     (cell_data[i])
			);
		end
	endgenerate

	// Result and new fill count of the request in its execute phase.
	always_comb begin
		status    = ST_OK;
		out_value = '0;
		count_d   = count_q;
		unique case (op_q)
			OP_ENQ: begin
				if (count_q == CW'(DEPTH)) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_DEQ: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					out_value = cell_data[0];
					count_d   = count_q - CW'(1);
				end
			end
			OP_DEL: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (found[DEPTH]) begin
					count_d = count_q - CW'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_d};

	// Request registers and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= accept;
			if (busy_q) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tdata[OP_W-1:0];
			value_q <= s_tdata[OP_W +: VALUE_W];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_q) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			out_data_q <= {{(OUT_W - STATUS_W - VALUE_W - OCC_W){1'b0}},
				occ_ext[OCC_W-1:0], out_value, status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The fill count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// The fill count moves only in an execute phase.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> count_q == $past(count_q))
		else $error("fill count changed outside execute phase");

	// The busy flag never stays set into the next cycle.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("execute phase longer than one cycle");

	// The result slot is free whenever a result is being written.
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_valid_q)
		else $error("result written over a waiting result");

endmodule
